// ----- design/center_window_auto_exposure_macros.svh -----
// Assertion helpers for the top-level design file.
`ifndef CENTER_WINDOW_AUTO_EXPOSURE_MACROS_SVH
`define CENTER_WINDOW_AUTO_EXPOSURE_MACROS_SVH

// Check post in the same cycle as pre.
`define CWAE_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Check post in the cycle after pre.
`define CWAE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- design/cwae_pkg.sv -----
package cwae_pkg;

   localparam int HALF_WINDOW_DEF = 256;
   localparam int MAX_DIM_DEF     = 8192;

   localparam int PIX_W      = 16;
   localparam int EXP_W      = 16;
   localparam int EXP_IDX_W  = 4;
   localparam int CFG_DIM_W  = 14;
   localparam int SUM_W      = 35;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam longint unsigned TARGET_LEVEL = 64'd40000;

   localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RESET  = CFG_DIM_W'(1024);
   localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RESET = CFG_DIM_W'(1024);
   localparam logic [EXP_W-1:0]     EXPOSURE_MIN_RESET = EXP_W'(1);
   localparam logic [EXP_W-1:0]     EXPOSURE_MAX_RESET = EXP_W'(65535);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE_MIN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE_MAX = CSR_IDX_W'(3);

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_MUL,
      SEQ_ADD,
      SEQ_DIV,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic step;
      logic last;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic busy;
      logic sum_clear;
   } seq_stat_type;

endpackage

// ----- design/cwae_window.sv -----
module cwae_window #(
   parameter int HALF_WINDOW = cwae_pkg::HALF_WINDOW_DEF,
   parameter int MAX_DIM     = cwae_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cwae_pkg::win_ctrl_type         ctrl,
   input  logic [cwae_pkg::PIX_W-1:0]     pixel,
   input  logic [cwae_pkg::CFG_DIM_W-1:0] frame_width,
   input  logic [cwae_pkg::CFG_DIM_W-1:0] frame_height,
   output logic [cwae_pkg::SUM_W-1:0]     sum
);
   import cwae_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CMP_W  = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
   localparam int HW_W   = $clog2(HALF_WINDOW + 1);
   localparam int SPAN_W = ((DIM_W > HW_W) ? DIM_W : HW_W) + 1;
   localparam int INC_W  = DIM_W + 1;
   localparam int ACC_W  = SUM_W + 1;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [INC_W-1:0] col_inc, row_inc;
   logic [ACC_W-1:0] sum_add;
   logic             in_win;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [CMP_W-1:0] ve;
      ve = CMP_W'(v);
      if (ve == '0)
         return DIM_W'(1);
      if (ve > CMP_W'(MAX_DIM))
         return DIM_W'(MAX_DIM);
      return DIM_W'(ve);
   endfunction

   function automatic logic in_span(input logic [CNT_W-1:0] pos,
                                    input logic [DIM_W-1:0] dim);
      logic [SPAN_W-1:0] p;
      logic [SPAN_W-1:0] mid;
      logic [SPAN_W-1:0] hw;
      p   = SPAN_W'(pos);
      mid = SPAN_W'(dim >> 1);
      hw  = SPAN_W'(HALF_WINDOW);
      return ((p + hw) >= mid) && (p < (mid + hw));
   endfunction

   assign w_eff   = clamp_dim(frame_width);
   assign h_eff   = clamp_dim(frame_height);
   assign in_win  = in_span(col_ff, w_eff) && in_span(row_ff, h_eff);
   assign col_inc = INC_W'(col_ff) + INC_W'(1);
   assign row_inc = INC_W'(row_ff) + INC_W'(1);
   assign sum_add = ACC_W'(sum_ff) + ACC_W'(pixel);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end else if (ctrl.step) begin
         // saturate rather than wrap when frame_end never comes
         if (in_win) begin
            sum_in = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         end
         if (ctrl.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= INC_W'(w_eff)) begin
            col_in = '0;
            row_in = (row_inc == INC_W'(MAX_DIM)) ? '0 : row_inc[CNT_W-1:0];
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ----- design/cwae_alu.sv -----
module cwae_alu #(
   parameter int WIDTH = 56
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] res,
   output logic             borrow
);
   logic [WIDTH:0] full;

   always_comb begin
      if (sub)
         full = {1'b0, a} - {1'b0, b};
      else
         full = {1'b0, a} + {1'b0, b};
   end

   assign res    = full[WIDTH-1:0];
   // carry out on add, borrow (a below b) on subtract
   assign borrow = full[WIDTH];

endmodule

// ----- design/cwae_seq.sv -----
module cwae_seq #(
   parameter int HALF_WINDOW = cwae_pkg::HALF_WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cwae_pkg::SUM_W-1:0] sum,
   input  logic [cwae_pkg::EXP_W-1:0] exp_min,
   input  logic [cwae_pkg::EXP_W-1:0] exp_max,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [cwae_pkg::EXP_W-1:0] rsp_new_exposure,
   output logic                       rsp_dark_window,
   output cwae_pkg::seq_stat_type     stat
);
   import cwae_pkg::*;

   localparam longint unsigned AREA = 64'(4 * HALF_WINDOW * HALF_WINDOW);
   localparam longint unsigned GAIN = TARGET_LEVEL * AREA;
   localparam int GAIN_W = $clog2(GAIN + 1);
   localparam int NUM_W  = GAIN_W + EXP_W;
   localparam int DVD_W  = ((NUM_W + 1 > SUM_W) ? NUM_W + 1 : SUM_W) + 1;
   localparam int DEN_W  = SUM_W + 1;
   localparam int ALU_W  = (DVD_W > DEN_W + 1) ? DVD_W : DEN_W + 1;
   localparam int STEP_W = $clog2(DVD_W);

   seq_state_type state_ff, state_in;

   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [EXP_W-1:0]     exp_ff, exp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [EXP_W-1:0]     rsp_exp_ff, rsp_exp_in;
   logic                 rsp_dark_ff, rsp_dark_in;

   logic [ALU_W-1:0]     alu_a, alu_b, alu_res;
   logic                 alu_sub, alu_borrow;
   logic [DEN_W-1:0]     den;
   logic [DEN_W:0]       div_shift;
   logic [EXP_IDX_W-1:0] bit_idx;
   logic                 sum_zero;
   logic [EXP_W-1:0]     result;

   cwae_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   assign den       = {sum, 1'b0};
   assign div_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign bit_idx   = ~cnt_ff[EXP_IDX_W-1:0];
   assign sum_zero  = (sum == '0);

   // clamp the quotient; a zero sum saturates to the maximum
   always_comb begin
      if (sum_zero)
         result = exp_max;
      else if (dvd_ff < DVD_W'(exp_min))
         result = exp_min;
      else if (dvd_ff > DVD_W'(exp_max))
         result = exp_max;
      else
         result = dvd_ff[EXP_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:  if (start) state_in = SEQ_CHECK;
         SEQ_CHECK: state_in = sum_zero ? SEQ_DONE : SEQ_MUL;
         SEQ_MUL:   if (cnt_ff == STEP_W'(EXP_W - 1)) state_in = SEQ_ADD;
         SEQ_ADD:   state_in = SEQ_DIV;
         SEQ_DIV:   if (cnt_ff == STEP_W'(DVD_W - 1)) state_in = SEQ_DONE;
         SEQ_DONE:  state_in = SEQ_IDLE;
         default:   state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      alu_a          = '0;
      alu_b          = '0;
      alu_sub        = 1'b0;
      cnt_in         = cnt_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      exp_in         = exp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_exp_in     = rsp_exp_ff;
      rsp_dark_in    = rsp_dark_ff;
      stat.busy      = (state_ff != SEQ_IDLE);
      stat.sum_clear = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
         end
         SEQ_CHECK: begin
            cnt_in = '0;
            dvd_in = '0;
            rem_in = '0;
         end
         SEQ_MUL: begin
            // shift-add over the exposure bits, most significant first
            alu_a  = ALU_W'({dvd_ff, 1'b0});
            alu_b  = exp_ff[bit_idx] ? ALU_W'(GAIN) : '0;
            dvd_in = alu_res[DVD_W-1:0];
            cnt_in = cnt_ff + STEP_W'(1);
         end
         SEQ_ADD: begin
            // form 2*num + sum for round half up
            alu_a  = ALU_W'({dvd_ff, 1'b0});
            alu_b  = ALU_W'(sum);
            dvd_in = alu_res[DVD_W-1:0];
            cnt_in = '0;
         end
         SEQ_DIV: begin
            alu_a   = ALU_W'(div_shift);
            alu_b   = ALU_W'(den);
            alu_sub = 1'b1;
            rem_in  = alu_borrow ? div_shift[DEN_W-1:0] : alu_res[DEN_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], !alu_borrow};
            cnt_in  = cnt_ff + STEP_W'(1);
         end
         SEQ_DONE: begin
            exp_in         = result;
            rsp_valid_in   = 1'b1;
            rsp_exp_in     = result;
            rsp_dark_in    = sum_zero;
            stat.sum_clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         exp_ff       <= EXPOSURE_MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_dark_ff <= rsp_dark_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_exposure = rsp_exp_ff;
   assign rsp_dark_window  = rsp_dark_ff;

endmodule

// ----- design/center_window_auto_exposure.sv -----
// Centre-window auto exposure.
// req_*: one pixel request per handshake, in row-major order, with req_frame_end
//   high on a frame's last pixel. Plain pixels are taken one per cycle when not busy.
// rsp_*: one result per frame: the new clamped exposure and a dark flag, held
//   in an output register until rsp_ready takes it.
// csr_*: register writes (0 width, 1 height, 2 exposure min, 3 exposure max);
//   taken while no frame_end request is being worked on and no result waits.
// Sequence: a frame_end request runs 1 check, 16 shift-add multiply steps,
//   1 rounding add, D restoring divide steps (D = dividend width, 52 by
//   default) and 1 write-back; a zero window sum goes from the check straight
//   to the write-back. Multiply, add and divide share one adder/subtractor
//   under a sequencer, and req_ready stays low while the sequencer runs.
// Stall: while a result waits, plain pixels are still taken, but a frame_end
//   request is held off until the result has been taken.
// Reset: synchronous; clears counters, window sum and output valid, restores
//   the register defaults and sets the current exposure to 1.
`include "center_window_auto_exposure_macros.svh"

module center_window_auto_exposure #(
   parameter int HALF_WINDOW = cwae_pkg::HALF_WINDOW_DEF,
   parameter int MAX_DIM     = cwae_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cwae_pkg::PIX_W-1:0]      req_pixel_value,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cwae_pkg::EXP_W-1:0]      rsp_new_exposure,
   output logic                            rsp_dark_window,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cwae_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cwae_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cwae_pkg::*;

   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [EXP_W-1:0]     exp_min_ff, exp_min_in;
   logic [EXP_W-1:0]     exp_max_ff, exp_max_in;

   win_ctrl_type         win_ctrl;
   seq_stat_type         seq_stat;
   logic [SUM_W-1:0]     window_sum;
   logic                 req_accept;
   logic                 csr_write;

   // hold off all requests while the sequencer runs, and a frame_end while a result still waits
   assign req_ready  = !seq_stat.busy && !(req_frame_end && rsp_valid);
   assign req_accept = req_valid && req_ready;

   // keep the limits steady while a result is in flight
   assign csr_ready = !seq_stat.busy && !rsp_valid;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      exp_min_in = exp_min_ff;
      exp_max_in = exp_max_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in   = csr_wdata[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT: height_in  = csr_wdata[CFG_DIM_W-1:0];
            CSR_EXPOSURE_MIN: exp_min_in = csr_wdata[EXP_W-1:0];
            CSR_EXPOSURE_MAX: exp_max_in = csr_wdata[EXP_W-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= FRAME_WIDTH_RESET;
         height_ff  <= FRAME_HEIGHT_RESET;
         exp_min_ff <= EXPOSURE_MIN_RESET;
         exp_max_ff <= EXPOSURE_MAX_RESET;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         exp_min_ff <= exp_min_in;
         exp_max_ff <= exp_max_in;
      end
   end

   // advance the counters on every accepted pixel; the sum is cleared in the
   // write-back step
   assign win_ctrl.step  = req_accept;
   assign win_ctrl.last  = req_frame_end;
   assign win_ctrl.clear = seq_stat.sum_clear;

   cwae_window #(
      .HALF_WINDOW (HALF_WINDOW),
      .MAX_DIM     (MAX_DIM)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (win_ctrl),
      .pixel        (req_pixel_value),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .sum          (window_sum)
   );

   // the sequencer starts on the cycle after the final pixel, once the sum
   // includes that pixel
   cwae_seq #(
      .HALF_WINDOW (HALF_WINDOW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (req_accept && req_frame_end),
      .sum              (window_sum),
      .exp_min          (exp_min_ff),
      .exp_max          (exp_max_ff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_new_exposure (rsp_new_exposure),
      .rsp_dark_window  (rsp_dark_window),
      .stat             (seq_stat)
   );

   `CWAE_ASSERT_NEXT(a_frame_end_starts_seq, req_accept && req_frame_end, seq_stat.busy)
   `CWAE_ASSERT_SAME(a_dark_gives_max, rsp_valid && rsp_dark_window, rsp_new_exposure == exp_max_ff)
   `CWAE_ASSERT_SAME(a_result_clamped, rsp_valid, (rsp_new_exposure <= exp_max_ff) || (rsp_new_exposure == exp_min_ff))

endmodule
